// ===== rtl/core/spu_adpcm_pkg.sv =====
package spu_adpcm_pkg;

  localparam logic [3:0] POS_HEADER = 4'd0;
  localparam logic [3:0] POS_FLAGS  = 4'd1;
  localparam logic [3:0] POS_LAST   = 4'd15;
  localparam logic [3:0] PRED_MAX   = 4'd4;

  localparam int SAMPLE_W = 32;
  localparam int COEF_W   = 8;
  localparam int PROD_W   = SAMPLE_W;

  localparam logic [1:0] PEND_NONE = 2'd0;
  localparam logic [1:0] PEND_HIGH = 2'd1;
  localparam logic [1:0] PEND_BOTH = 2'd2;

  typedef logic signed [COEF_W-1:0] coef_t;

  function automatic coef_t coef_newest(input logic [2:0] pred);
    coef_t k;
    case (pred)
      3'd1:    k = 8'sd60;
      3'd2:    k = 8'sd115;
      3'd3:    k = 8'sd98;
      3'd4:    k = 8'sd122;
      default: k = 8'sd0;
    endcase
    return k;
  endfunction

  function automatic coef_t coef_older(input logic [2:0] pred);
    coef_t k;
    case (pred)
      3'd2:    k = -8'sd52;
      3'd3:    k = -8'sd55;
      3'd4:    k = -8'sd60;
      default: k = 8'sd0;
    endcase
    return k;
  endfunction

endpackage

// ===== rtl/core/spu_adpcm_block_decoder.sv =====
// Channel  Dir  tdata                    tuser
// in_      in   [7:0] in_byte            [0] new_tone
// out_     out  [31:0] sample            [0] loop_start_mark [1] loop_end_mark [2] repeat_mark
//                                        (tlast = block_last)
// Header and flags bytes give no transaction.
// A data byte gives two samples, low nibble first: one shared nibble decoder and the history
// registers produce one sample per cycle into the output register while the output is not stalled.
// rst_n is synchronous, active low, and clears position, header state and history.
// A stalled output holds the decoder; input is taken again once the second
// nibble of the pending byte is emitted.
module spu_adpcm_block_decoder
  import spu_adpcm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  input  logic        in_tuser,   // [0] new_tone
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] sample
  output logic        out_tlast,
  output logic [2:0]  out_tuser   // [0] loop_start [1] loop_end [2] repeat
);

  logic [3:0]                 byte_pos_r, byte_pos_nxt;
  logic [3:0]                 shift_r, shift_nxt;
  logic [2:0]                 pred_r, pred_nxt;
  logic [2:0]                 flags_r, flags_nxt;
  logic signed [SAMPLE_W-1:0] hist_new_r, hist_new_nxt;
  logic signed [SAMPLE_W-1:0] hist_old_r, hist_old_nxt;
  logic [1:0]                 pend_r, pend_nxt;
  logic [7:0]                 data_r, data_nxt;
  logic                       last_r, last_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [SAMPLE_W-1:0]        out_data_r, out_data_nxt;
  logic                       out_last_r, out_last_nxt;
  logic [2:0]                 out_user_r, out_user_nxt;

  logic                       in_fire;
  logic                       emit;
  logic [3:0]                 pos_eff;
  logic [3:0]                 nib;
  logic signed [SAMPLE_W-1:0] nib_ext;
  logic signed [SAMPLE_W-1:0] base;
  logic signed [PROD_W-1:0]   prod_new, prod_old;
  logic signed [SAMPLE_W-1:0] term_new, term_old;
  logic signed [SAMPLE_W-1:0] smp;

  assign emit      = (pend_r != PEND_NONE) && (!out_valid_r || out_tready);
  assign in_tready = (pend_r == PEND_NONE) || ((pend_r == PEND_HIGH) && emit);
  assign in_fire   = in_tvalid && in_tready;
  assign pos_eff   = in_tuser ? POS_HEADER : byte_pos_r;

  assign nib      = (pend_r == PEND_BOTH) ? data_r[3:0] : data_r[7:4];
  assign nib_ext  = {{16{nib[3]}}, nib, 12'b0};
  assign base     = nib_ext >>> shift_r;
  assign prod_new = PROD_W'(hist_new_r) * PROD_W'(coef_newest(pred_r));
  assign prod_old = PROD_W'(hist_old_r) * PROD_W'(coef_older(pred_r));
  assign term_new = signed'(prod_new[SAMPLE_W-1:0]) >>> 6;
  assign term_old = signed'(prod_old[SAMPLE_W-1:0]) >>> 6;
  assign smp      = base + term_new + term_old;

  always_comb begin
    byte_pos_nxt  = byte_pos_r;
    shift_nxt     = shift_r;
    pred_nxt      = pred_r;
    flags_nxt     = flags_r;
    hist_new_nxt  = hist_new_r;
    hist_old_nxt  = hist_old_r;
    pend_nxt      = pend_r;
    data_nxt      = data_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    out_user_nxt  = out_user_r;

    if (emit) begin
      hist_old_nxt  = hist_new_r;
      hist_new_nxt  = smp;
      pend_nxt      = pend_r - 2'd1;
      out_valid_nxt = 1'b1;
      out_data_nxt  = smp;
      out_last_nxt  = (pend_r == PEND_HIGH) && last_r;
      out_user_nxt  = {flags_r[1], flags_r[0], flags_r[2]};
    end

    if (in_fire) begin
      if (in_tuser) begin
        hist_new_nxt = '0;
        hist_old_nxt = '0;
      end
      byte_pos_nxt = pos_eff + 4'd1;
      case (pos_eff)
        POS_HEADER: begin
          shift_nxt = in_tdata[3:0];
          pred_nxt  = ({1'b0, in_tdata[6:4]} <= PRED_MAX && !in_tdata[7]) ?
                      in_tdata[6:4] : 3'd0;
        end
        POS_FLAGS: begin
          flags_nxt = in_tdata[2:0];
        end
        default: begin
          data_nxt = in_tdata;
          last_nxt = (pos_eff == POS_LAST);
          pend_nxt = PEND_BOTH;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_pos_r  <= '0;
      shift_r     <= '0;
      pred_r      <= '0;
      flags_r     <= '0;
      hist_new_r  <= '0;
      hist_old_r  <= '0;
      pend_r      <= PEND_NONE;
      out_valid_r <= 1'b0;
    end else begin
      byte_pos_r  <= byte_pos_nxt;
      shift_r     <= shift_nxt;
      pred_r      <= pred_nxt;
      flags_r     <= flags_nxt;
      hist_new_r  <= hist_new_nxt;
      hist_old_r  <= hist_old_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r     <= data_nxt;
    last_r     <= last_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
    out_user_r <= out_user_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_user_r;

`ifndef SYNTHESIS
  a_pend_range: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r != 2'd3)
    else $error("pending nibble count out of range");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> pend_r != PEND_BOTH)
    else $error("input taken with two nibbles pending");

  a_low_then_high: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r == PEND_BOTH && emit) |=> pend_r == PEND_HIGH)
    else $error("high nibble not queued after low nibble");

  a_data_queued: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && pos_eff != POS_HEADER && pos_eff != POS_FLAGS) |=> pend_r == PEND_BOTH)
    else $error("data byte not queued for decode");

  a_last_on_high: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && pend_r == PEND_BOTH) |=> !out_tlast)
    else $error("block end marked on low nibble");
`endif

endmodule
